### rtl/core/crsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_pkg
// shared types, codes and sizes of the rc link frame receiver
// ----------------------------------------------------------------------------
package crsf_pkg;

   // frame buffer sizing
   localparam int MAX_FRAME_BYTES = 64;
   localparam int FRAME_CAP       = (MAX_FRAME_BYTES < 64) ? MAX_FRAME_BYTES : 64;
   localparam int IDX_W           = $clog2(FRAME_CAP);
   localparam int CNT_W           = $clog2(FRAME_CAP + 1);

   // field widths
   localparam int FUNC_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 6;
   localparam int TIMER_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // input selector codes
   localparam logic [FUNC_W-1:0] FUNC_BYTE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SYNC       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RC_TYPE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_LIMIT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CRC_POLY   = 2'd3;

   // register reset values
   localparam logic [BYTE_W-1:0]  SYNC_RESET       = 8'hC8;
   localparam logic [BYTE_W-1:0]  RC_TYPE_RESET    = 8'h16;
   localparam logic [TIMER_W-1:0] IDLE_LIMIT_RESET = 16'd250;
   localparam logic [BYTE_W-1:0]  CRC_POLY_RESET   = 8'hD5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SEND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load_status;
      logic load_frame;
      logic step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic frame_done;
      logic replay_last;
   } sts_type;

endpackage

### rtl/core/crsf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_if
// valid/ready channels for input items and result beats
// ----------------------------------------------------------------------------
interface crsf_req_if;
   import crsf_pkg::*;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, func, rx_byte, input ready);
   modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface crsf_rsp_if;
   import crsf_pkg::*;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte;
   logic [INDEX_W-1:0] out_index;
   logic               frame_valid;
   logic               last;
   logic               paired;

   modport source (output valid, out_byte, out_index, frame_valid, last, paired,
                   input ready);
   modport sink   (input valid, out_byte, out_index, frame_valid, last, paired,
                   output ready);
endinterface

### rtl/core/crsf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_ctrl
// sequencer for item acceptance and frame replay
// ----------------------------------------------------------------------------
module crsf_ctrl
   import crsf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.out_free && sts.frame_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (sts.out_free) begin
               state_in = sts.replay_last ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      cmd             = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = sts.out_free;
            cmd.accept      = req_valid && sts.out_free;
            cmd.load_status = req_valid && sts.out_free && !sts.frame_done;
         end
         ST_FETCH: begin
         end
         ST_SEND: begin
            cmd.load_frame = sts.out_free;
            cmd.step       = sts.out_free && !sts.replay_last;
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/core/crsf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_dp
// frame buffer, crc, link timer, registers and result register
// ----------------------------------------------------------------------------
module crsf_dp
   import crsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [FUNC_W-1:0]     func,
   input  logic [BYTE_W-1:0]     rx_byte,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   output logic [INDEX_W-1:0]    rsp_out_index,
   output logic                  rsp_frame_valid,
   output logic                  rsp_last,
   output logic                  rsp_paired
);

   function automatic logic [BYTE_W-1:0] crc_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b,
                                                    input logic [BYTE_W-1:0] poly);
      logic [BYTE_W-1:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ poly) : (c << 1);
      end
      return c;
   endfunction

   // configuration
   logic [BYTE_W-1:0]  sync_ff, rc_type_ff, poly_ff;
   logic [TIMER_W-1:0] limit_ff;

   // frame state
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [BYTE_W-1:0]  crc_ff, crc_in;
   logic               link_ff, link_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [BYTE_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0]  ftype_ff, ftype_in;
   logic [TIMER_W-1:0] timer_inc;
   logic [BYTE_W-1:0]  cur_type;
   logic               frame_done;
   logic               mem_we;

   // buffer
   logic [BYTE_W-1:0]  mem [FRAME_CAP];
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [BYTE_W-1:0]  rd_data_ff;
   logic               replay_last;

   // result register
   logic               valid_ff, valid_in;
   logic [BYTE_W-1:0]  obyte_ff, obyte_in;
   logic [INDEX_W-1:0] oidx_ff, oidx_in;
   logic               ofv_ff, ofv_in;
   logic               olast_ff, olast_in;
   logic               opaired_ff, opaired_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= SYNC_RESET;
         rc_type_ff <= RC_TYPE_RESET;
         limit_ff   <= IDLE_LIMIT_RESET;
         poly_ff    <= CRC_POLY_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SYNC:       sync_ff    <= csr_wdata[BYTE_W-1:0];
            REG_RC_TYPE:    rc_type_ff <= csr_wdata[BYTE_W-1:0];
            REG_IDLE_LIMIT: limit_ff   <= csr_wdata[TIMER_W-1:0];
            REG_CRC_POLY:   poly_ff    <= csr_wdata[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign timer_inc = (timer_ff != '1) ? timer_ff + 1'b1 : timer_ff;
   assign cur_type  = (fill_ff == CNT_W'(2)) ? rx_byte : ftype_ff;

   // offered byte is the crc byte of a frame and matches
   assign frame_done = (func == FUNC_BYTE) && link_ff && (fill_ff > CNT_W'(1)) &&
                       (9'(fill_ff) > {1'b0, len_ff}) && (crc_ff == rx_byte);

   always_comb begin
      fill_in    = fill_ff;
      crc_in     = crc_ff;
      link_in    = link_ff;
      timer_in   = timer_ff;
      len_in     = len_ff;
      ftype_in   = ftype_ff;
      mem_we     = 1'b0;
      if (cmd.accept) begin
         unique case (func)
            FUNC_TICK: begin
               timer_in = timer_inc;
               if (link_ff && (timer_inc > limit_ff)) begin
                  link_in = 1'b0;
               end
            end
            FUNC_RESTART: begin
               link_in  = 1'b1;
               timer_in = '0;
               fill_in  = '0;
               crc_in   = '0;
            end
            FUNC_BYTE: begin
               if (link_ff && !((fill_ff == '0) && (rx_byte != sync_ff))) begin
                  mem_we  = 1'b1;
                  fill_in = fill_ff + 1'b1;
                  if (fill_ff == CNT_W'(1)) begin
                     // length must cover type and crc and fit the buffer
                     len_in = rx_byte;
                     if ((rx_byte < 8'd2) ||
                         ({1'b0, rx_byte} + 9'd2 > 9'(FRAME_CAP))) begin
                        fill_in = '0;
                        crc_in  = '0;
                     end
                  end else if (fill_ff != '0) begin
                     if (fill_ff == CNT_W'(2)) begin
                        ftype_in = rx_byte;
                     end
                     if (cur_type == rc_type_ff) begin
                        timer_in = '0;
                     end
                     if (9'(fill_ff) <= {1'b0, len_ff}) begin
                        crc_in = crc_update(crc_ff, rx_byte, poly_ff);
                     end else begin
                        // crc byte: frame ends either way
                        fill_in    = '0;
                        crc_in     = '0;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         crc_ff    <= '0;
         link_ff   <= 1'b1;
         timer_ff  <= '0;
         rd_idx_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         crc_ff    <= crc_in;
         link_ff   <= link_in;
         timer_ff  <= timer_in;
         rd_idx_ff <= rd_idx_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff     <= len_in;
      ftype_ff   <= ftype_in;
      obyte_ff   <= obyte_in;
      oidx_ff    <= oidx_in;
      ofv_ff     <= ofv_in;
      olast_ff   <= olast_in;
      opaired_ff <= opaired_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[fill_ff[IDX_W-1:0]] <= rx_byte;
      end
      rd_data_ff <= mem[rd_idx_ff];
   end

   assign replay_last = (8'(rd_idx_ff) == len_ff + 8'd1);

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.accept) begin
         rd_idx_in = '0;
      end else if (cmd.step) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end
   end

   always_comb begin
      obyte_in   = obyte_ff;
      oidx_in    = oidx_ff;
      ofv_in     = ofv_ff;
      olast_in   = olast_ff;
      opaired_in = opaired_ff;
      valid_in   = rsp_ready ? 1'b0 : valid_ff;
      if (cmd.load_status) begin
         obyte_in   = '0;
         oidx_in    = '0;
         ofv_in     = 1'b0;
         olast_in   = 1'b1;
         opaired_in = link_in;
         valid_in   = 1'b1;
      end else if (cmd.load_frame) begin
         obyte_in   = rd_data_ff;
         oidx_in    = INDEX_W'(rd_idx_ff);
         ofv_in     = 1'b1;
         olast_in   = replay_last;
         opaired_in = link_ff;
         valid_in   = 1'b1;
      end
   end

   assign sts.out_free    = !valid_ff || rsp_ready;
   assign sts.frame_done  = frame_done;
   assign sts.replay_last = replay_last;

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = obyte_ff;
   assign rsp_out_index   = oidx_ff;
   assign rsp_frame_valid = ofv_ff;
   assign rsp_last        = olast_ff;
   assign rsp_paired      = opaired_ff;

endmodule

### rtl/core/crsf_frame_receiver.sv
`timescale 1ns / 1ps
// the status result of an item is registered and shown in the cycle after its beat is taken
// throughput: one item per cycle while results are taken at once and no frame replay is under way
// a crc byte that closes a valid frame of L+2 bytes replays all of its bytes in order,
//   one registered buffer read and one result register load per byte
// reset: synchronous, active high; clears control state and loads register
//   defaults; the frame buffer is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// crsf_frame_receiver
// rc link frame receiver with sync hunt, length check, crc8 and link timer
// ----------------------------------------------------------------------------
module crsf_frame_receiver
   import crsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   crsf_req_if.sink              req_chan,
   crsf_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // controller: takes items only when the result register is free
   crsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: frame state, buffer memory and result register
   crsf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .func            (req_chan.func),
      .rx_byte         (req_chan.rx_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_out_byte    (rsp_chan.out_byte),
      .rsp_out_index   (rsp_chan.out_index),
      .rsp_frame_valid (rsp_chan.frame_valid),
      .rsp_last        (rsp_chan.last),
      .rsp_paired      (rsp_chan.paired)
   );

endmodule

### rtl/core/crsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_checker
// port level checks of the frame receiver
// ----------------------------------------------------------------------------
module crsf_checker
   import crsf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [BYTE_W-1:0]  rsp_out_byte,
   input logic [INDEX_W-1:0] rsp_out_index,
   input logic               rsp_frame_valid,
   input logic               rsp_last,
   input logic               rsp_paired
);

   // stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_out_index) && $stable(rsp_frame_valid) && $stable(rsp_last) &&
      $stable(rsp_paired))
      else $error("result beat changed while stalled");

   // status beat shape
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_valid |->
      rsp_last && (rsp_out_byte == '0) && (rsp_out_index == '0))
      else $error("malformed status beat");

   // frames are at least four bytes
   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_valid && (rsp_out_index == '0) |-> !rsp_last)
      else $error("frame ended at its first byte");

   // no new item while a replay is under way
   a_replay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_valid && !rsp_last |-> !req_ready)
      else $error("input taken during frame replay");

   // result register empty after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat after reset");

endmodule

bind crsf_frame_receiver crsf_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_byte    (rsp_chan.out_byte),
   .rsp_out_index   (rsp_chan.out_index),
   .rsp_frame_valid (rsp_chan.frame_valid),
   .rsp_last        (rsp_chan.last),
   .rsp_paired      (rsp_chan.paired)
);
